@@ hdl/tfls_pkg.sv @@
// Shared types and constants for the text file lint scanner.
// No dependencies; imported by tfls_scan, tfls_emit and text_file_lint_scanner.
package tfls_pkg;

	// Counter width default and event report limit per problem kind
	localparam int COUNT_BITS_DEF = 32;
	localparam int MAX_REPORTED   = 8;

	// Character codes
	localparam logic [7:0] CH_TAB     = 8'h09;
	localparam logic [7:0] CH_LF      = 8'h0A;
	localparam logic [7:0] CH_CR      = 8'h0D;
	localparam logic [7:0] CH_SP      = 8'h20;
	localparam logic [7:0] CH_TILDE   = 8'h7E;
	localparam logic [7:0] CH_BOM0    = 8'hEF;
	localparam logic [7:0] CH_BOM1    = 8'hBB;
	localparam logic [7:0] CH_BOM2    = 8'hBF;
	localparam logic [7:0] RESET_BYTE = 8'h40;

	// Problem counter slots
	localparam int CNT_TAB   = 0;
	localparam int CNT_TRAIL = 1;
	localparam int CNT_LONG  = 2;
	localparam int CNT_BAD   = 3;

	// Pending event bits in the emitter, lowest goes out first
	localparam int P_FIRST = 0;
	localparam int P_TRAIL = 1;
	localparam int P_LONG  = 2;
	localparam int P_SUM   = 3;

	// Configuration register indexes
	localparam int CFG_IDX_BITS = 2;
	localparam logic [CFG_IDX_BITS-1:0] REG_MAX_LEN   = 2'd0;
	localparam logic [CFG_IDX_BITS-1:0] REG_TABS_OK   = 2'd1;
	localparam logic [CFG_IDX_BITS-1:0] REG_CHECK_LEN = 2'd2;

	typedef enum logic [2:0] {
		KIND_TAB   = 3'd0,
		KIND_TRAIL = 3'd1,
		KIND_LONG  = 3'd2,
		KIND_BAD   = 3'd3,
		KIND_SUM   = 3'd4
	} kind_t;

	typedef enum logic [2:0] {
		VERD_CRLF  = 3'd0,
		VERD_CR    = 3'd1,
		VERD_MIXED = 3'd2,
		VERD_LF    = 3'd3,
		VERD_NONE  = 3'd4
	} verdict_t;

	typedef enum logic [1:0] {
		STAT_OK      = 2'd0,
		STAT_MISSING = 2'd1,
		STAT_MULTI   = 2'd2
	} status_t;

	typedef struct packed {
		logic [15:0] max_len;
		logic        tabs_allowed;
		logic        check_len;
	} cfg_t;

	localparam cfg_t CFG_RESET = '{max_len: 16'd120, tabs_allowed: 1'b0, check_len: 1'b1};

	// All events caused by one byte, handed from the scanner to the emitter
	typedef struct packed {
		logic              ev_first;      // tab or disallowed byte event
		logic              first_is_bad;
		logic              ev_trail;
		logic              ev_long;
		logic              ev_sum;
		logic [31:0]       line;
		logic [15:0]       col;
		logic [7:0]        bad_byte;
		verdict_t          verdict;
		status_t           status;
		logic              bom;
		logic [3:0][31:0]  totals;
	} scan_bundle_t;

endpackage

@@ hdl/tfls_scan.sv @@
// Input register, scan state and per-byte event logic of the lint scanner.
// Depends on tfls_pkg; feeds an event bundle to tfls_emit for each byte that raises an event.
module tfls_scan #(
	parameter int COUNT_BITS = tfls_pkg::COUNT_BITS_DEF
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  tfls_pkg::cfg_t         cfg,
	input  logic                   byte_valid,
	output logic                   byte_stall,
	input  logic [7:0]             data_byte,
	input  logic                   end_of_file,
	output logic                   bndl_valid,
	output tfls_pkg::scan_bundle_t bndl,
	input  logic                   bndl_ready
);
	import tfls_pkg::*;

	localparam logic [COUNT_BITS-1:0] LIMIT = COUNT_BITS'(MAX_REPORTED);

	logic        valid_s1;
	logic [7:0]  byte_s1;
	logic        eof_s1;

	logic [7:0]  prev_q, prev2_q;
	logic        flag_cr_q, flag_lf_q, flag_crlf_q, flag_bom_q;
	logic [31:0] line_q;
	logic [15:0] col_q;
	logic [COUNT_BITS-1:0] cnt_q [4];
	logic [COUNT_BITS-1:0] cnt_d [4];
	logic [31:0] tot [4];

	logic        is_cr, is_lf, is_nl, is_tab, is_bom, is_bad, prev_cr;
	logic        flag_cr_d, flag_lf_d, flag_crlf_d, flag_bom_d;
	logic [31:0] line_d, line_at;
	logic [15:0] col_d, col_at;
	logic        trail_hit, long_hit;
	logic [3:0]  bump;
	logic        has_event, adv, accept;

	always_comb begin
		is_cr   = byte_s1 == CH_CR;
		is_lf   = byte_s1 == CH_LF;
		is_nl   = is_cr || is_lf;
		is_tab  = byte_s1 == CH_TAB;
		is_bom  = byte_s1 == CH_BOM0 || byte_s1 == CH_BOM1 || byte_s1 == CH_BOM2;
		is_bad  = !is_tab && !is_bom && !is_nl &&
			!(byte_s1 >= CH_SP && byte_s1 <= CH_TILDE);
		prev_cr = prev_q == CH_CR;

		line_d  = ((prev_cr || is_lf) && line_q != '1) ? line_q + 32'd1 : line_q;
		line_at = (line_d == '1) ? line_d : line_d + 32'd1;
		col_at  = (col_q == '1) ? col_q : col_q + 16'd1;
		col_d   = is_nl ? '0 : col_at;

		// a CR as the very last byte still counts as a bare CR
		flag_cr_d   = flag_cr_q | (prev_cr && !is_lf) | (eof_s1 && is_cr);
		flag_lf_d   = flag_lf_q | (!prev_cr && is_lf);
		flag_crlf_d = flag_crlf_q | (prev_cr && is_lf);
		flag_bom_d  = flag_bom_q | is_bom;

		trail_hit = is_nl && (prev_q == CH_SP || prev_q == CH_TAB);
		long_hit  = is_nl && (col_q > cfg.max_len);

		bump[CNT_TAB]   = is_tab;
		bump[CNT_TRAIL] = trail_hit;
		bump[CNT_LONG]  = long_hit;
		bump[CNT_BAD]   = is_bad;
		for (int i = 0; i < 4; i++)
			cnt_d[i] = (bump[i] && cnt_q[i] != '1) ? cnt_q[i] + COUNT_BITS'(1) : cnt_q[i];

		bndl = '0;
		bndl.ev_first     = (is_tab && cnt_q[CNT_TAB] < LIMIT && !cfg.tabs_allowed) ||
			(is_bad && cnt_q[CNT_BAD] < LIMIT);
		bndl.first_is_bad = is_bad;
		bndl.ev_trail     = trail_hit && cnt_q[CNT_TRAIL] < LIMIT;
		bndl.ev_long      = long_hit && cnt_q[CNT_LONG] < LIMIT && cfg.check_len;
		bndl.ev_sum       = eof_s1;
		bndl.line         = line_at;
		bndl.col          = col_at;
		bndl.bad_byte     = is_bad ? byte_s1 : '0;
		bndl.bom          = flag_bom_d;
		for (int i = 0; i < 4; i++)
			bndl.totals[i] = tot[i];

		// after the shift: previous = byte_s1, second = prev_q, third = prev2_q
		bndl.status = STAT_OK;
		if (flag_cr_d) begin
			bndl.verdict = VERD_CR;
		end else if (flag_lf_d && flag_crlf_d) begin
			bndl.verdict = VERD_MIXED;
		end else if (flag_lf_d) begin
			bndl.verdict = VERD_LF;
			if (!is_lf)
				bndl.status = STAT_MISSING;
			else if (prev_q == CH_LF)
				bndl.status = STAT_MULTI;
		end else if (flag_crlf_d) begin
			bndl.verdict = VERD_CRLF;
			if (prev_q != CH_CR || !is_lf)
				bndl.status = STAT_MISSING;
			else if (prev2_q == CH_LF)
				bndl.status = STAT_MULTI;
		end else begin
			bndl.verdict = VERD_NONE;
		end

		has_event  = bndl.ev_first || bndl.ev_trail || bndl.ev_long || bndl.ev_sum;
		bndl_valid = valid_s1 && has_event;
		adv        = valid_s1 && (!has_event || bndl_ready);
		byte_stall = valid_s1 && !adv;
		accept     = byte_valid && !byte_stall;
	end

	// totals above 32 bits read as all ones
	for (genvar g = 0; g < 4; g++) begin : g_tot
		if (COUNT_BITS > 32) begin : g_wide
			assign tot[g] = (|cnt_d[g][COUNT_BITS-1:32]) ? '1 : cnt_d[g][31:0];
		end else begin : g_narrow
			assign tot[g] = 32'(cnt_d[g]);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (adv) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			byte_s1 <= data_byte;
			eof_s1  <= end_of_file;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_q      <= RESET_BYTE;
			prev2_q     <= RESET_BYTE;
			flag_cr_q   <= 1'b0;
			flag_lf_q   <= 1'b0;
			flag_crlf_q <= 1'b0;
			flag_bom_q  <= 1'b0;
			line_q      <= '0;
			col_q       <= '0;
			for (int i = 0; i < 4; i++)
				cnt_q[i] <= '0;
		end else if (adv && eof_s1) begin
			// file done: scan state back to its start values
			prev_q      <= RESET_BYTE;
			prev2_q     <= RESET_BYTE;
			flag_cr_q   <= 1'b0;
			flag_lf_q   <= 1'b0;
			flag_crlf_q <= 1'b0;
			flag_bom_q  <= 1'b0;
			line_q      <= '0;
			col_q       <= '0;
			for (int i = 0; i < 4; i++)
				cnt_q[i] <= '0;
		end else if (adv) begin
			prev_q      <= byte_s1;
			prev2_q     <= prev_q;
			flag_cr_q   <= flag_cr_d;
			flag_lf_q   <= flag_lf_d;
			flag_crlf_q <= flag_crlf_d;
			flag_bom_q  <= flag_bom_d;
			line_q      <= line_d;
			col_q       <= col_d;
			for (int i = 0; i < 4; i++)
				cnt_q[i] <= cnt_d[i];
		end
	end

	a_eof_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(adv && eof_s1) |=> (line_q == '0 && col_q == '0 && prev_q == RESET_BYTE &&
			cnt_q[CNT_TAB] == '0))
		else $error("scan state not cleared after end of file");

	a_col_step: assert property (@(posedge clk) disable iff (!arst_n)
		(adv && !eof_s1 && !is_nl && col_q != '1) |=> (col_q == $past(col_q) + 16'd1))
		else $error("column counter did not advance");

	a_hold_when_stalled: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && !adv) |=> (valid_s1 && $stable(byte_s1) && $stable(line_q)))
		else $error("scan stage moved while blocked");

endmodule

@@ hdl/tfls_emit.sv @@
// Result register and event sequencer: sends the events of one bundle in order.
// Depends on tfls_pkg; takes bundles from tfls_scan.
module tfls_emit (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   bndl_valid,
	input  tfls_pkg::scan_bundle_t bndl,
	output logic                   bndl_ready,
	output logic                   event_valid,
	input  logic                   event_stall,
	output logic [2:0]             kind,
	output logic [31:0]            line_number,
	output logic [15:0]            column_number,
	output logic [7:0]             bad_byte,
	output logic [2:0]             ending_verdict,
	output logic [1:0]             end_status,
	output logic                   has_bom,
	output logic [31:0]            tab_total,
	output logic [31:0]            trailing_total,
	output logic [31:0]            overlength_total,
	output logic [31:0]            disallowed_total,
	output logic                   last_of_run
);
	import tfls_pkg::*;

	logic [3:0]   pend_s2;
	scan_bundle_t data_s2;
	logic [3:0]   low, rest;
	logic         take, load;

	always_comb begin
		low         = pend_s2 & (~pend_s2 + 4'd1);
		rest        = pend_s2 & ~low;
		event_valid = |pend_s2;
		last_of_run = event_valid && (rest == '0);
		take        = event_valid && !event_stall;
		bndl_ready  = !event_valid || (take && last_of_run);
		load        = bndl_valid && bndl_ready;

		kind             = KIND_SUM;
		line_number      = data_s2.line;
		column_number    = data_s2.col;
		bad_byte         = '0;
		ending_verdict   = '0;
		end_status       = '0;
		has_bom          = 1'b0;
		tab_total        = '0;
		trailing_total   = '0;
		overlength_total = '0;
		disallowed_total = '0;
		priority if (low[P_FIRST]) begin
			kind     = data_s2.first_is_bad ? KIND_BAD : KIND_TAB;
			bad_byte = data_s2.bad_byte;
		end else if (low[P_TRAIL]) begin
			kind = KIND_TRAIL;
		end else if (low[P_LONG]) begin
			kind = KIND_LONG;
		end else begin
			// summary, or nothing pending
			kind             = KIND_SUM;
			line_number      = 32'd1;
			column_number    = 16'd1;
			ending_verdict   = data_s2.verdict;
			end_status       = data_s2.status;
			has_bom          = data_s2.bom;
			tab_total        = data_s2.totals[CNT_TAB];
			trailing_total   = data_s2.totals[CNT_TRAIL];
			overlength_total = data_s2.totals[CNT_LONG];
			disallowed_total = data_s2.totals[CNT_BAD];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_s2 <= '0;
		end else if (load) begin
			pend_s2[P_FIRST] <= bndl.ev_first;
			pend_s2[P_TRAIL] <= bndl.ev_trail;
			pend_s2[P_LONG]  <= bndl.ev_long;
			pend_s2[P_SUM]   <= bndl.ev_sum;
		end else if (take) begin
			pend_s2 <= rest;
		end
	end

	always_ff @(posedge clk) begin
		if (load)
			data_s2 <= bndl;
	end

	a_sum_last: assert property (@(posedge clk) disable iff (!arst_n)
		(event_valid && kind == KIND_SUM) |-> last_of_run)
		else $error("summary is not the last event of its byte");

	a_run_continues: assert property (@(posedge clk) disable iff (!arst_n)
		(take && !last_of_run) |=> event_valid)
		else $error("events of one byte were dropped");

	a_no_nl_mix: assert property (@(posedge clk) disable iff (!arst_n)
		!(pend_s2[P_FIRST] && (pend_s2[P_TRAIL] || pend_s2[P_LONG])))
		else $error("tab or bad byte event mixed with line end events");

endmodule

@@ hdl/text_file_lint_scanner.sv @@
// Text file lint scanner: one file byte per transaction in, problem and summary events out.
// Byte input channel: byte_valid / byte_stall with data_byte and end_of_file.
// Event output channel: event_valid / event_stall with kind, location, byte and summary.
// Configuration channel: cfg_valid / cfg_ready (always ready), cfg_index, cfg_data;
// index 0 line length limit, 1 tabs_allowed, 2 check_line_length; other indexes are ignored.
// Write configuration only while no byte is in flight.
// A byte passes the input register, then its events are presented from the event register.
// Throughput: one byte per cycle while byte_stall is low; a byte that raises k events holds
// the event register until all k are taken (k at most 3: line end problems plus the summary),
// and bytes that raise no event pass through without using the event register.
// The input register and the event register each hold one transaction, so a new byte
// is taken while an event waits for the receiver; when the receiver stalls, both fill
// and byte_stall rises.
// The byte marked end_of_file adds a summary event and returns all scan state
// (counters, line ending flags, byte history) to start values; configuration is kept.
// Reset clears scan state, empties both registers and loads the configuration defaults.
// Depends on tfls_pkg, tfls_scan and tfls_emit.
module text_file_lint_scanner #(
	parameter int COUNT_BITS = tfls_pkg::COUNT_BITS_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [tfls_pkg::CFG_IDX_BITS-1:0] cfg_index,
	input  logic [15:0]                       cfg_data,
	input  logic                              byte_valid,
	output logic                              byte_stall,
	input  logic [7:0]                        data_byte,
	input  logic                              end_of_file,
	output logic                              event_valid,
	input  logic                              event_stall,
	output logic [2:0]                        kind,
	output logic [31:0]                       line_number,
	output logic [15:0]                       column_number,
	output logic [7:0]                        bad_byte,
	output logic [2:0]                        ending_verdict,
	output logic [1:0]                        end_status,
	output logic                              has_bom,
	output logic [31:0]                       tab_total,
	output logic [31:0]                       trailing_total,
	output logic [31:0]                       overlength_total,
	output logic [31:0]                       disallowed_total,
	output logic                              last_of_run
);
	import tfls_pkg::*;

	cfg_t         cfg_q;
	logic         bndl_valid, bndl_ready;
	scan_bundle_t bndl;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= CFG_RESET;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_MAX_LEN:   cfg_q.max_len      <= cfg_data;
				REG_TABS_OK:   cfg_q.tabs_allowed <= cfg_data[0];
				REG_CHECK_LEN: cfg_q.check_len    <= cfg_data[0];
				default: ;
			endcase
		end
	end

	tfls_scan #(.COUNT_BITS(COUNT_BITS)) u_scan (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg         (cfg_q),
		.byte_valid  (byte_valid),
		.byte_stall  (byte_stall),
		.data_byte   (data_byte),
		.end_of_file (end_of_file),
		.bndl_valid  (bndl_valid),
		.bndl        (bndl),
		.bndl_ready  (bndl_ready)
	);

	tfls_emit u_emit (
		.clk              (clk),
		.arst_n           (arst_n),
		.bndl_valid       (bndl_valid),
		.bndl             (bndl),
		.bndl_ready       (bndl_ready),
		.event_valid      (event_valid),
		.event_stall      (event_stall),
		.kind             (kind),
		.line_number      (line_number),
		.column_number    (column_number),
		.bad_byte         (bad_byte),
		.ending_verdict   (ending_verdict),
		.end_status       (end_status),
		.has_bom          (has_bom),
		.tab_total        (tab_total),
		.trailing_total   (trailing_total),
		.overlength_total (overlength_total),
		.disallowed_total (disallowed_total),
		.last_of_run      (last_of_run)
	);

endmodule
